// File: sv/rgbep_pkg.sv
`default_nettype none

package rgbep_pkg;

  // Panel defaults
  localparam int unsigned PANEL_WIDTH_DEF  = 960;
  localparam int unsigned PANEL_HEIGHT_DEF = 540;

  // Field widths
  localparam int unsigned COLOR_W = 16;
  localparam int unsigned COORD_W = 10;
  localparam int unsigned SIZE_W  = 11;
  localparam int unsigned ADDR_W  = 18;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;
  // Signed logical coordinate: covers -1024 .. 3069 plus rotation offsets
  localparam int unsigned LCOORD_W = 13;
  // Address product width (10-bit row times 11-bit pitch)
  localparam int unsigned PROD_W = 21;

  // Gray weights
  localparam logic [15:0] GRAY_R_WT = 16'd76;
  localparam logic [15:0] GRAY_G_WT = 16'd150;
  localparam logic [15:0] GRAY_B_WT = 16'd30;

  // Masks and thresholds
  localparam logic [BYTE_W-1:0] MASK_HI  = 8'hF0;
  localparam logic [BYTE_W-1:0] MASK_LO  = 8'h0F;
  localparam logic [BYTE_W-1:0] MASK_MSB = 8'h80;
  localparam logic [BYTE_W-1:0] GRAY_THRESH = 8'd128;

  // Mirror bits
  localparam int unsigned MIRROR_X_BIT = 0;
  localparam int unsigned MIRROR_Y_BIT = 1;

  // Register reset values
  localparam logic [COORD_W-1:0] AREA_LEFT_RST   = 10'd0;
  localparam logic [COORD_W-1:0] AREA_TOP_RST    = 10'd0;
  localparam logic [SIZE_W-1:0]  AREA_WIDTH_RST  = 11'd960;
  localparam logic [SIZE_W-1:0]  AREA_HEIGHT_RST = 11'd540;
  localparam logic [1:0]         MIRROR_RST      = 2'd0;
  localparam logic               DITHER_RST      = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AREA_LEFT   = 3'd0,
    CFG_AREA_TOP    = 3'd1,
    CFG_AREA_WIDTH  = 3'd2,
    CFG_AREA_HEIGHT = 3'd3,
    CFG_MIRROR      = 3'd4,
    CFG_ROTATION    = 3'd5,
    CFG_FORMAT      = 3'd6,
    CFG_DITHER      = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

  typedef enum logic {
    FMT_1BPP = 1'b0,
    FMT_4BPP = 1'b1
  } fmt_e;

  // 4x4 Bayer level, indexed by row then column
  function automatic logic [3:0] bayer_level(input logic [1:0] y, input logic [1:0] x);
    logic [3:0] lvl;
    case ({y, x})
      4'h0: lvl = 4'd0;
      4'h1: lvl = 4'd8;
      4'h2: lvl = 4'd2;
      4'h3: lvl = 4'd10;
      4'h4: lvl = 4'd12;
      4'h5: lvl = 4'd4;
      4'h6: lvl = 4'd14;
      4'h7: lvl = 4'd6;
      4'h8: lvl = 4'd3;
      4'h9: lvl = 4'd11;
      4'hA: lvl = 4'd1;
      4'hB: lvl = 4'd9;
      4'hC: lvl = 4'd15;
      4'hD: lvl = 4'd7;
      4'hE: lvl = 4'd13;
      4'hF: lvl = 4'd5;
      default: lvl = 4'd0;
    endcase
    return lvl;
  endfunction

endpackage

`default_nettype wire

// File: sv/rgbep_intf.sv
`default_nettype none

interface rgbep_pix_if;
  logic                               valid;
  logic                               ready;
  logic [rgbep_pkg::COLOR_W-1:0]      pixel_color;
  logic [rgbep_pkg::COORD_W-1:0]      col_in_area;
  logic [rgbep_pkg::COORD_W-1:0]      row_in_area;

  modport source (output valid, output pixel_color, output col_in_area,
                  output row_in_area, input ready);
  modport sink   (input valid, input pixel_color, input col_in_area,
                  input row_in_area, output ready);
endinterface

interface rgbep_res_if;
  logic                               valid;
  logic                               ready;
  logic [rgbep_pkg::ADDR_W-1:0]       byte_address;
  logic [rgbep_pkg::BYTE_W-1:0]       write_data;
  logic [rgbep_pkg::BYTE_W-1:0]       write_mask;
  logic                               out_of_range;

  modport source (output valid, output byte_address, output write_data,
                  output write_mask, output out_of_range, input ready);
  modport sink   (input valid, input byte_address, input write_data,
                  input write_mask, input out_of_range, output ready);
endinterface

`default_nettype wire

// File: sv/rgb565_to_epaper_pixel_pack.sv
`default_nettype none

// Channel   Dir  Payload                                            Handshake
// pix_i     in   pixel_color[15:0] col_in_area[9:0] row_in_area[9:0] valid/ready
// res_o     out  byte_address[17:0] write_data[7:0] write_mask[7:0]
//                out_of_range                                       valid/ready
// cfg       in   cfg_we_i cfg_idx_i[2:0] cfg_wdata_i[10:0]          write only
//
// One item per cycle sustained while res_o is taken. An accepted item moves
// through the stage-1, stage-2 and stage-3 registers in order to res_o.
// Stages: gray + mirror/offset, rotation + panel range check, address
// multiply + mask/data. The stage-3 register is the output register.
// rst_ni clears stage valid bits and loads register defaults.
// A stalled output holds each full stage, though an empty stage still loads;
// pix_i.ready drops only when all three stages are full and res_o is not taken.

module rgb565_to_epaper_pixel_pack #(
  parameter int unsigned PANEL_WIDTH  = rgbep_pkg::PANEL_WIDTH_DEF,
  parameter int unsigned PANEL_HEIGHT = rgbep_pkg::PANEL_HEIGHT_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  rgbep_pix_if.sink                               pix_i,
  rgbep_res_if.source                             res_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [rgbep_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [rgbep_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  localparam int unsigned LW = rgbep_pkg::LCOORD_W;
  localparam int unsigned CW = rgbep_pkg::COORD_W;
  localparam int unsigned PW = rgbep_pkg::PROD_W;

  localparam logic signed [LW-1:0] PANEL_W_S   = LW'(PANEL_WIDTH);
  localparam logic signed [LW-1:0] PANEL_H_S   = LW'(PANEL_HEIGHT);
  localparam logic signed [LW-1:0] PANEL_W1_S  = LW'(PANEL_WIDTH - 1);
  localparam logic signed [LW-1:0] PANEL_H1_S  = LW'(PANEL_HEIGHT - 1);
  // Row pitch in bytes for each format; a partial last byte rounds up
  localparam logic [PW-1:0] PITCH_4BPP = PW'((PANEL_WIDTH + 1) / 2);
  localparam logic [PW-1:0] PITCH_1BPP = PW'((PANEL_WIDTH + 7) / 8);

  // ---------------- configuration registers ----------------
  logic [CW-1:0]                   area_left_q, area_top_q;
  logic [rgbep_pkg::SIZE_W-1:0]    area_width_q, area_height_q;
  logic [1:0]                      mirror_q;
  rgbep_pkg::rot_e                 rotation_q;
  rgbep_pkg::fmt_e                 format_q;
  logic                            dither_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_left_q   <= rgbep_pkg::AREA_LEFT_RST;
      area_top_q    <= rgbep_pkg::AREA_TOP_RST;
      area_width_q  <= rgbep_pkg::AREA_WIDTH_RST;
      area_height_q <= rgbep_pkg::AREA_HEIGHT_RST;
      mirror_q      <= rgbep_pkg::MIRROR_RST;
      rotation_q    <= rgbep_pkg::ROT_0;
      format_q      <= rgbep_pkg::FMT_4BPP;
      dither_q      <= rgbep_pkg::DITHER_RST;
    end else if (cfg_we_i) begin
      case (rgbep_pkg::cfg_idx_e'(cfg_idx_i))
        rgbep_pkg::CFG_AREA_LEFT:   area_left_q   <= cfg_wdata_i[CW-1:0];
        rgbep_pkg::CFG_AREA_TOP:    area_top_q    <= cfg_wdata_i[CW-1:0];
        rgbep_pkg::CFG_AREA_WIDTH:  area_width_q  <= cfg_wdata_i;
        rgbep_pkg::CFG_AREA_HEIGHT: area_height_q <= cfg_wdata_i;
        rgbep_pkg::CFG_MIRROR:      mirror_q      <= cfg_wdata_i[1:0];
        rgbep_pkg::CFG_ROTATION:    rotation_q    <= rgbep_pkg::rot_e'(cfg_wdata_i[1:0]);
        rgbep_pkg::CFG_FORMAT:      format_q      <= rgbep_pkg::fmt_e'(cfg_wdata_i[0]);
        rgbep_pkg::CFG_DITHER:      dither_q      <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline flow control ----------------
  logic s1_vld_q, s2_vld_q, s3_vld_q;
  logic s1_en, s2_en, s3_en;

  assign s3_en = !s3_vld_q || res_o.ready;
  assign s2_en = !s2_vld_q || s3_en;
  assign s1_en = !s1_vld_q || s2_en;
  assign pix_i.ready = s1_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      if (s1_en) s1_vld_q <= pix_i.valid;
      if (s2_en) s2_vld_q <= s1_vld_q;
      if (s3_en) s3_vld_q <= s2_vld_q;
    end
  end

  // ---------------- stage 1: gray, mirror, area offset ----------------
  logic [4:0]  red5, blue5;
  logic [5:0]  grn5;
  logic [7:0]  red8, grn8, blue8;
  logic [15:0] gray_sum;
  logic signed [LW-1:0] col_s, row_s, mx, my;
  logic signed [LW-1:0] lx_d, ly_d;
  logic [7:0]           gray_d;

  always_comb begin
    red5  = pix_i.pixel_color[15:11];
    grn5  = pix_i.pixel_color[10:5];
    blue5 = pix_i.pixel_color[4:0];
    red8  = {red5, red5[4:2]};
    grn8  = {grn5, grn5[5:4]};
    blue8 = {blue5, blue5[4:2]};
    gray_sum = 16'(red8) * rgbep_pkg::GRAY_R_WT
             + 16'(grn8) * rgbep_pkg::GRAY_G_WT
             + 16'(blue8) * rgbep_pkg::GRAY_B_WT;
    gray_d = gray_sum[15:8];

    col_s = $signed({3'b000, pix_i.col_in_area});
    row_s = $signed({3'b000, pix_i.row_in_area});
    mx = mirror_q[rgbep_pkg::MIRROR_X_BIT]
       ? $signed({2'b00, area_width_q}) - 13'sd1 - col_s : col_s;
    my = mirror_q[rgbep_pkg::MIRROR_Y_BIT]
       ? $signed({2'b00, area_height_q}) - 13'sd1 - row_s : row_s;
    lx_d = $signed({3'b000, area_left_q}) + mx;
    ly_d = $signed({3'b000, area_top_q}) + my;
  end

  logic signed [LW-1:0] s1_lx_q, s1_ly_q;
  logic [7:0]           s1_gray_q;

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_lx_q   <= lx_d;
      s1_ly_q   <= ly_d;
      s1_gray_q <= gray_d;
    end
  end

  // ---------------- stage 2: rotation, panel check ----------------
  logic signed [LW-1:0] dx, dy;
  logic                 oor_d;

  always_comb begin
    case (rotation_q)
      rgbep_pkg::ROT_90: begin
        dx = PANEL_W1_S - s1_ly_q;
        dy = s1_lx_q;
      end
      rgbep_pkg::ROT_180: begin
        dx = PANEL_W1_S - s1_lx_q;
        dy = PANEL_H1_S - s1_ly_q;
      end
      rgbep_pkg::ROT_270: begin
        dx = s1_ly_q;
        dy = PANEL_H1_S - s1_lx_q;
      end
      default: begin
        dx = s1_lx_q;
        dy = s1_ly_q;
      end
    endcase
    oor_d = (dx < 0) || (dy < 0) || (dx >= PANEL_W_S) || (dy >= PANEL_H_S);
  end

  logic [CW-1:0] s2_ux_q, s2_uy_q;
  logic [7:0]    s2_gray_q;
  logic          s2_oor_q;

  always_ff @(posedge clk_i) begin
    if (s2_en) begin
      s2_ux_q   <= dx[CW-1:0];
      s2_uy_q   <= dy[CW-1:0];
      s2_gray_q <= s1_gray_q;
      s2_oor_q  <= oor_d;
    end
  end

  // ---------------- stage 3: address, mask, data ----------------
  logic [PW-1:0]                 pitch, addr_full;
  logic [rgbep_pkg::BYTE_W-1:0]  mask_d, data_d;
  logic [7:0]                    thresh;
  logic                          white;

  always_comb begin
    thresh = dither_q
           ? {rgbep_pkg::bayer_level(s2_uy_q[1:0], s2_ux_q[1:0]), 4'b0000}
           : rgbep_pkg::GRAY_THRESH;
    white  = s2_gray_q >= thresh;
    if (format_q == rgbep_pkg::FMT_4BPP) begin
      pitch     = PITCH_4BPP;
      addr_full = PW'(s2_uy_q) * pitch + PW'(s2_ux_q >> 1);
      if (s2_ux_q[0]) begin
        mask_d = rgbep_pkg::MASK_LO;
        data_d = {4'b0000, s2_gray_q[7:4]};
      end else begin
        mask_d = rgbep_pkg::MASK_HI;
        data_d = {s2_gray_q[7:4], 4'b0000};
      end
    end else begin
      pitch     = PITCH_1BPP;
      addr_full = PW'(s2_uy_q) * pitch + PW'(s2_ux_q >> 3);
      mask_d    = rgbep_pkg::MASK_MSB >> s2_ux_q[2:0];
      data_d    = white ? mask_d : '0;
    end
    // off-panel items carry an all-zero payload
    if (s2_oor_q) begin
      addr_full = '0;
      mask_d    = '0;
      data_d    = '0;
    end
  end

  logic [rgbep_pkg::ADDR_W-1:0] s3_addr_q;
  logic [rgbep_pkg::BYTE_W-1:0] s3_data_q, s3_mask_q;
  logic                         s3_oor_q;

  always_ff @(posedge clk_i) begin
    if (s3_en) begin
      s3_addr_q <= addr_full[rgbep_pkg::ADDR_W-1:0];
      s3_data_q <= data_d;
      s3_mask_q <= mask_d;
      s3_oor_q  <= s2_oor_q;
    end
  end

  assign res_o.valid        = s3_vld_q;
  assign res_o.byte_address = s3_addr_q;
  assign res_o.write_data   = s3_data_q;
  assign res_o.write_mask   = s3_mask_q;
  assign res_o.out_of_range = s3_oor_q;

  // ---------------- assertions ----------------
  a_oor_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.out_of_range |->
      res_o.write_mask == '0 && res_o.write_data == '0 && res_o.byte_address == '0)
    else $error("off-panel item with nonzero payload");

  a_data_in_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.write_data & ~res_o.write_mask) == '0)
    else $error("write data outside write mask");

  a_nibble_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.out_of_range && format_q == rgbep_pkg::FMT_4BPP |->
      res_o.write_mask == rgbep_pkg::MASK_HI || res_o.write_mask == rgbep_pkg::MASK_LO)
    else $error("bad 4bpp mask");

  a_bit_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.out_of_range && format_q == rgbep_pkg::FMT_1BPP |->
      $onehot(res_o.write_mask))
    else $error("bad 1bpp mask");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && s2_vld_q && s3_vld_q && !res_o.ready |-> !pix_i.ready)
    else $error("input taken while pipeline is full and stalled");

endmodule

`default_nettype wire
